[sv/sit_pkg.sv]
`timescale 1ns / 1ps
package sit_pkg;

	localparam int CAPACITY_DEF    = 256;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed field widths of the stream payload
	localparam int CMD_W   = 2;
	localparam int VAL_W   = 32;
	localparam int INDEX_W = 9;
	localparam int POS_W   = 9;
	localparam int COUNT_W = 9;
	localparam int STAT_W  = 2;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// datapath micro-operations issued by the controller
	localparam int UOP_W = 5;
	localparam logic [UOP_W-1:0] UOP_NOP        = 5'd0;
	localparam logic [UOP_W-1:0] UOP_LOAD       = 5'd1;
	localparam logic [UOP_W-1:0] UOP_SET_FULL   = 5'd2;
	localparam logic [UOP_W-1:0] UOP_SET_RANGE  = 5'd3;
	localparam logic [UOP_W-1:0] UOP_APPEND     = 5'd4;
	localparam logic [UOP_W-1:0] UOP_INIT_LH    = 5'd5;
	localparam logic [UOP_W-1:0] UOP_INIT_LS    = 5'd6;
	localparam logic [UOP_W-1:0] UOP_RD_IDX     = 5'd7;
	localparam logic [UOP_W-1:0] UOP_INS_INIT   = 5'd8;
	localparam logic [UOP_W-1:0] UOP_RD_MID     = 5'd9;
	localparam logic [UOP_W-1:0] UOP_RD_L       = 5'd10;
	localparam logic [UOP_W-1:0] UOP_POS_L      = 5'd11;
	localparam logic [UOP_W-1:0] UOP_ADD_STEP   = 5'd12;
	localparam logic [UOP_W-1:0] UOP_ADD_LAST   = 5'd13;
	localparam logic [UOP_W-1:0] UOP_RD_PTRM1   = 5'd14;
	localparam logic [UOP_W-1:0] UOP_WR_PTR     = 5'd15;
	localparam logic [UOP_W-1:0] UOP_WR_POS     = 5'd16;
	localparam logic [UOP_W-1:0] UOP_FIND_STEP  = 5'd17;
	localparam logic [UOP_W-1:0] UOP_RD_PTR     = 5'd18;
	localparam logic [UOP_W-1:0] UOP_LS_STEP    = 5'd19;
	localparam logic [UOP_W-1:0] UOP_RM_CAP     = 5'd20;
	localparam logic [UOP_W-1:0] UOP_RD_PTRP1   = 5'd21;
	localparam logic [UOP_W-1:0] UOP_WR_PTR_INC = 5'd22;
	localparam logic [UOP_W-1:0] UOP_DEC        = 5'd23;

	typedef struct packed {
		logic [UOP_W-1:0] uop;
		logic             out_load;
	} sit_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             sorted;
		logic             full;
		logic             idx_gt_cnt;
		logic             idx_ge_cnt;
		logic             l_lt_h;
		logic             l_le_h;
		logic             l_lt_cnt;
		logic             ptr_gt_pos;
		logic             ptr_lt_cnt;
		logic             ptr1_lt_cnt;
		logic             leq_dv;
		logic             leq_vd;
		logic             eq;
		logic             out_free;
	} sit_stat_t;

endpackage

[sv/sit_ctrl.sv]
`timescale 1ns / 1ps
module sit_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sit_pkg::sit_stat_t stat,
	output sit_pkg::sit_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_BA      = 4'd2;
	localparam logic [3:0] S_BA_CMP  = 4'd3;
	localparam logic [3:0] S_BA_LAST = 4'd4;
	localparam logic [3:0] S_SH      = 4'd5;
	localparam logic [3:0] S_SH_WR   = 4'd6;
	localparam logic [3:0] S_BF      = 4'd7;
	localparam logic [3:0] S_BF_CMP  = 4'd8;
	localparam logic [3:0] S_LS      = 4'd9;
	localparam logic [3:0] S_LS_CMP  = 4'd10;
	localparam logic [3:0] S_RM_RD   = 4'd11;
	localparam logic [3:0] S_RM      = 4'd12;
	localparam logic [3:0] S_RM_WR   = 4'd13;
	localparam logic [3:0] S_FIN     = 4'd14;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.uop      = sit_pkg::UOP_NOP;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.uop = sit_pkg::UOP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.cmd)
					sit_pkg::CMD_ADD: begin
						if (stat.full) begin
							cmd.uop = sit_pkg::UOP_SET_FULL;
							state_d = S_FIN;
						end else if (stat.sorted) begin
							cmd.uop = sit_pkg::UOP_INIT_LH;
							state_d = S_BA;
						end else begin
							cmd.uop = sit_pkg::UOP_APPEND;
							state_d = S_FIN;
						end
					end
					sit_pkg::CMD_FIND: begin
						if (stat.sorted) begin
							cmd.uop = sit_pkg::UOP_INIT_LH;
							state_d = S_BF;
						end else begin
							cmd.uop = sit_pkg::UOP_INIT_LS;
							state_d = S_LS;
						end
					end
					sit_pkg::CMD_REMOVE: begin
						if (stat.idx_ge_cnt) begin
							cmd.uop = sit_pkg::UOP_SET_RANGE;
							state_d = S_FIN;
						end else begin
							cmd.uop = sit_pkg::UOP_RD_IDX;
							state_d = S_RM_RD;
						end
					end
					default: begin
						if (stat.idx_gt_cnt) begin
							cmd.uop = sit_pkg::UOP_SET_RANGE;
							state_d = S_FIN;
						end else if (stat.full) begin
							cmd.uop = sit_pkg::UOP_SET_FULL;
							state_d = S_FIN;
						end else begin
							cmd.uop = sit_pkg::UOP_INS_INIT;
							state_d = S_SH;
						end
					end
				endcase
			end
			S_BA: begin
				if (stat.l_lt_h) begin
					cmd.uop = sit_pkg::UOP_RD_MID;
					state_d = S_BA_CMP;
				end else if (stat.l_lt_cnt) begin
					cmd.uop = sit_pkg::UOP_RD_L;
					state_d = S_BA_LAST;
				end else begin
					cmd.uop = sit_pkg::UOP_POS_L;
					state_d = S_SH;
				end
			end
			S_BA_CMP: begin
				cmd.uop = sit_pkg::UOP_ADD_STEP;
				state_d = S_BA;
			end
			S_BA_LAST: begin
				cmd.uop = sit_pkg::UOP_ADD_LAST;
				state_d = S_SH;
			end
			S_SH: begin
				if (stat.ptr_gt_pos) begin
					cmd.uop = sit_pkg::UOP_RD_PTRM1;
					state_d = S_SH_WR;
				end else begin
					cmd.uop = sit_pkg::UOP_WR_POS;
					state_d = S_FIN;
				end
			end
			S_SH_WR: begin
				cmd.uop = sit_pkg::UOP_WR_PTR;
				state_d = S_SH;
			end
			S_BF: begin
				if (stat.l_le_h) begin
					cmd.uop = sit_pkg::UOP_RD_MID;
					state_d = S_BF_CMP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_BF_CMP: begin
				cmd.uop = sit_pkg::UOP_FIND_STEP;
				state_d = (stat.leq_dv && stat.leq_vd) ? S_FIN : S_BF;
			end
			S_LS: begin
				if (stat.ptr_lt_cnt) begin
					cmd.uop = sit_pkg::UOP_RD_PTR;
					state_d = S_LS_CMP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_LS_CMP: begin
				cmd.uop = sit_pkg::UOP_LS_STEP;
				state_d = stat.eq ? S_FIN : S_LS;
			end
			S_RM_RD: begin
				cmd.uop = sit_pkg::UOP_RM_CAP;
				state_d = S_RM;
			end
			S_RM: begin
				if (stat.ptr1_lt_cnt) begin
					cmd.uop = sit_pkg::UOP_RD_PTRP1;
					state_d = S_RM_WR;
				end else begin
					cmd.uop = sit_pkg::UOP_DEC;
					state_d = S_FIN;
				end
			end
			S_RM_WR: begin
				cmd.uop = sit_pkg::UOP_WR_PTR_INC;
				state_d = S_RM;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/sit_datapath.sv]
`timescale 1ns / 1ps
module sit_datapath #(
	parameter int CAPACITY    = sit_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sit_pkg::sit_cmd_t                 cmd,
	output sit_pkg::sit_stat_t                stat,
	input  logic                              sorted,
	input  logic [sit_pkg::CMD_W-1:0]         in_command,
	input  logic signed [sit_pkg::VAL_W-1:0]  in_value,
	input  logic [sit_pkg::INDEX_W-1:0]       in_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sit_pkg::POS_W-1:0]         out_position,
	output logic                              out_found,
	output logic signed [sit_pkg::VAL_W-1:0]  out_removed_value,
	output logic [sit_pkg::COUNT_W-1:0]       out_entry_count,
	output logic [sit_pkg::STAT_W-1:0]        out_status
);

	localparam int VW = VALUE_WIDTH;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int LW = CW + 1;
	localparam int IW = sit_pkg::INDEX_W;
	localparam int MW = (CW > IW) ? CW : IW;

	logic [VW-1:0] mem [CAPACITY];
	logic [VW-1:0] rdata_q;

	logic [sit_pkg::CMD_W-1:0]  cmd_q;
	logic [VW-1:0]              val_q;
	logic [IW-1:0]              idx_q;
	logic signed [LW-1:0]       l_q, h_q;
	logic [AW-1:0]              mid_q;
	logic [CW-1:0]              ptr_q, pos_q, count_q;
	logic                       found_q;
	logic [VW-1:0]              rem_q;
	logic [sit_pkg::STAT_W-1:0] st_q;

	logic [LW:0]          sum_w;
	logic [AW-1:0]        mid_w;
	logic signed [LW-1:0] cnt_s;
	logic [MW-1:0]        idx_m, cnt_m;
	logic [AW-1:0]        raddr, waddr;
	logic [VW-1:0]        wdata;
	logic                 we;
	logic                 leq_dv, leq_vd;

	// floor midpoint, both bounds are non-negative whenever it is used
	assign sum_w = {l_q[LW-1], l_q} + {h_q[LW-1], h_q};
	assign mid_w = AW'(sum_w[LW:1]);
	assign cnt_s = $signed(LW'(count_q));
	assign idx_m = MW'(idx_q);
	assign cnt_m = MW'(count_q);

	assign leq_dv = $signed(rdata_q) <= $signed(val_q);
	assign leq_vd = $signed(val_q) <= $signed(rdata_q);

	always_comb begin
		stat.cmd         = cmd_q;
		stat.sorted      = sorted;
		stat.full        = (count_q == CW'(CAPACITY));
		stat.idx_gt_cnt  = idx_m > cnt_m;
		stat.idx_ge_cnt  = idx_m >= cnt_m;
		stat.l_lt_h      = l_q < h_q;
		stat.l_le_h      = l_q <= h_q;
		stat.l_lt_cnt    = l_q < cnt_s;
		stat.ptr_gt_pos  = ptr_q > pos_q;
		stat.ptr_lt_cnt  = ptr_q < count_q;
		stat.ptr1_lt_cnt = (LW'(ptr_q) + LW'(1)) < LW'(count_q);
		stat.leq_dv      = leq_dv;
		stat.leq_vd      = leq_vd;
		stat.eq          = (rdata_q == val_q);
		stat.out_free    = !out_valid || out_ready;
	end

	always_comb begin
		raddr = '0;
		waddr = '0;
		wdata = val_q;
		we    = 1'b0;
		case (cmd.uop)
			sit_pkg::UOP_RD_MID:   raddr = mid_w;
			sit_pkg::UOP_RD_L:     raddr = AW'(l_q);
			sit_pkg::UOP_RD_IDX:   raddr = AW'(idx_q);
			sit_pkg::UOP_RD_PTRM1: raddr = AW'(ptr_q - CW'(1));
			sit_pkg::UOP_RD_PTR:   raddr = AW'(ptr_q);
			sit_pkg::UOP_RD_PTRP1: raddr = AW'(ptr_q + CW'(1));
			sit_pkg::UOP_APPEND: begin
				we    = 1'b1;
				waddr = AW'(count_q);
			end
			sit_pkg::UOP_WR_POS: begin
				we    = 1'b1;
				waddr = AW'(pos_q);
			end
			sit_pkg::UOP_WR_PTR, sit_pkg::UOP_WR_PTR_INC: begin
				we    = 1'b1;
				waddr = AW'(ptr_q);
				wdata = rdata_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.uop)
				sit_pkg::UOP_APPEND, sit_pkg::UOP_WR_POS: count_q <= count_q + CW'(1);
				sit_pkg::UOP_DEC:                         count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.uop)
			sit_pkg::UOP_LOAD: begin
				cmd_q   <= in_command;
				val_q   <= VW'($unsigned(in_value));
				idx_q   <= in_index;
				pos_q   <= '0;
				found_q <= 1'b0;
				rem_q   <= '0;
				st_q    <= sit_pkg::ST_OK;
			end
			sit_pkg::UOP_SET_FULL:  st_q <= sit_pkg::ST_FULL;
			sit_pkg::UOP_SET_RANGE: st_q <= sit_pkg::ST_RANGE;
			sit_pkg::UOP_APPEND:    pos_q <= count_q;
			sit_pkg::UOP_INIT_LH: begin
				l_q <= '0;
				h_q <= $signed(LW'(count_q) - LW'(1));
			end
			sit_pkg::UOP_INIT_LS: ptr_q <= '0;
			sit_pkg::UOP_INS_INIT: begin
				pos_q <= CW'(idx_q);
				ptr_q <= count_q;
			end
			sit_pkg::UOP_RD_MID: mid_q <= mid_w;
			sit_pkg::UOP_POS_L: begin
				pos_q <= CW'(l_q);
				ptr_q <= count_q;
			end
			sit_pkg::UOP_ADD_STEP: begin
				if (leq_dv) begin
					l_q <= $signed(LW'(mid_q) + LW'(1));
				end else begin
					h_q <= $signed(LW'(mid_q));
				end
			end
			sit_pkg::UOP_ADD_LAST: begin
				pos_q <= CW'(l_q) + CW'(leq_dv);
				ptr_q <= count_q;
			end
			sit_pkg::UOP_WR_PTR: ptr_q <= ptr_q - CW'(1);
			sit_pkg::UOP_FIND_STEP: begin
				if (leq_dv && leq_vd) begin
					found_q <= 1'b1;
					pos_q   <= CW'(mid_q);
				end else if (leq_dv) begin
					l_q <= $signed(LW'(mid_q) + LW'(1));
				end else begin
					h_q <= $signed(LW'(mid_q) - LW'(1));
				end
			end
			sit_pkg::UOP_LS_STEP: begin
				if (rdata_q == val_q) begin
					found_q <= 1'b1;
					pos_q   <= ptr_q;
				end else begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			sit_pkg::UOP_RM_CAP: begin
				rem_q <= rdata_q;
				pos_q <= CW'(idx_q);
				ptr_q <= CW'(idx_q);
			end
			sit_pkg::UOP_WR_PTR_INC: ptr_q <= ptr_q + CW'(1);
			default: ;
		endcase
	end

	// output register, holds a finished result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_position      <= sit_pkg::POS_W'(pos_q);
			out_found         <= found_q;
			out_removed_value <= $signed(sit_pkg::VAL_W'(rem_q));
			out_entry_count   <= sit_pkg::COUNT_W'(count_q);
			out_status        <= st_q;
		end
	end

endmodule

[sv/sorted_integer_table_core.sv]
`timescale 1ns / 1ps
// from acceptance to result valid: unsorted add and rejected commands go from dispatch straight to the result;
// sorted find reads and compares once per probe, unsorted find once per entry scanned;
// sorted add reads and compares once per probe, then moves each entry that is shifted up;
// insert moves each entry that is shifted up, remove moves each entry down
// throughput: one command at a time, the next is accepted the cycle the result turns valid;
// a result held by the sink stalls the next one. reset: arst_n clears the count, sets sorted mode
module sorted_integer_table_core #(
	parameter int CAPACITY    = sit_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[1:0], value[33:2], index[42:34], zero fill
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // position[8:0], found[9], removed_value[41:10],
	                              // entry_count[50:42], status[52:51], zero fill
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] ADDR_SORTED_MODE = 3'd0;

	sit_pkg::sit_cmd_t  cmd;
	sit_pkg::sit_stat_t stat;

	logic sorted_q;

	logic [sit_pkg::POS_W-1:0]        position;
	logic                             found;
	logic signed [sit_pkg::VAL_W-1:0] removed_value;
	logic [sit_pkg::COUNT_W-1:0]      entry_count;
	logic [sit_pkg::STAT_W-1:0]       status;

	// configuration register; user must write it only while no transaction is in flight (not enforced)
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr == ADDR_SORTED_MODE)) begin
			sorted_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == ADDR_SORTED_MODE) ? {31'd0, sorted_q} : 32'd0;

	// sequencer: walks binary search, linear scan and entry shifting
	sit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// entry ram, count, search bounds and the result register
	sit_datapath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.sorted            (sorted_q),
		.in_command        (s_tdata[1:0]),
		.in_value          ($signed(s_tdata[33:2])),
		.in_index          (s_tdata[42:34]),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_position      (position),
		.out_found         (found),
		.out_removed_value (removed_value),
		.out_entry_count   (entry_count),
		.out_status        (status)
	);

	// pack result fields from bit zero up
	assign m_tdata = {3'd0, status, entry_count, removed_value, found, position};

endmodule
